// ===== rtl/pidf_pkg.sv =====
// ---------------------------------------------------------------------------
// pidf_pkg: shared types and constants of the filtered-derivative PID block
// Fixed-point widths, configuration record, microcode word and helpers.
// ---------------------------------------------------------------------------
package pidf_pkg;

    // fixed point and counter sizes
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned CMP_W       = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    // field widths
    localparam int unsigned IN_W    = 32;
    localparam int unsigned DRIVE_W = 24;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned COEF_W  = 17;

    // datapath widths
    localparam int unsigned CHUNK_W  = 26;
    localparam int unsigned A_W      = 2 * CHUNK_W;
    localparam int unsigned G_W      = GAIN_W;
    localparam int unsigned PP_W     = CHUNK_W + 1 + G_W + 1;
    localparam int unsigned MACC_W   = PP_W + CHUNK_W;
    localparam int unsigned PRD_W    = 52;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned SPM_W    = IN_W + 1;
    localparam int unsigned EP_W     = 34;
    localparam int unsigned DIN_W    = 34;
    localparam int unsigned DD_W     = DIN_W + 1;
    localparam int unsigned UP_W     = 42;
    localparam int unsigned SUM_W    = 50;
    localparam int unsigned SAT_IN_W = 56;

    // 1.0 in the input format
    localparam logic signed [IN_W-1:0] ONE_Q = IN_W'(1) << FRAC_BITS;

    // saturation bounds of the 48-bit state, sign-extended to the wide sum
    localparam logic signed [SAT_IN_W-1:0] SAT_HI =
        {{(SAT_IN_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = ~SAT_HI;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_FACTOR  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_DECAY   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PROP   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DERIV  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = CFG_IDX_W'(7);

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integral_gain;
        logic [COEF_W-1:0]   deriv_factor;
        logic [COEF_W-1:0]   deriv_decay;
        logic [COEF_W-1:0]   weight_prop;
        logic [COEF_W-1:0]   weight_deriv;
        logic [DRIVE_W-1:0]  output_max;
        logic [PERIOD_W-1:0] sample_period;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:     GAIN_W'(3276800),
        integral_gain: GAIN_W'(655),
        deriv_factor:  COEF_W'(6489),
        deriv_decay:   COEF_W'(6554),
        weight_prop:   COEF_W'(65536),
        weight_deriv:  COEF_W'(65536),
        output_max:    DRIVE_W'(1310720),
        sample_period: PERIOD_W'(1000)
    };

    // microcode word
    localparam int unsigned STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_FIN = STEP_W'(20);

    typedef enum logic {CH_LO, CH_HI} t_chunk;
    typedef enum logic [2:0] {A_SP, A_EP, A_SPM, A_DS, A_DD, A_INNER} t_asel;
    typedef enum logic [2:0] {G_WB, G_WC, G_K, G_KI, G_DECAY, G_FACTOR} t_gsel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} t_acc;
    typedef enum logic [3:0] {
        WB_NONE, WB_EP, WB_DIN, WB_DD, WB_UP, WB_INTEG,
        WB_TMP, WB_INNER, WB_DS, WB_SUM, WB_CLAMP
    } t_wb;
    typedef enum logic [1:0] {J_NEXT, J_HOLD, J_DONE} t_jmp;

    typedef struct packed {
        t_chunk chunk;
        t_asel  asel;
        t_gsel  gsel;
        t_acc   acc;
        t_wb    wb;
        t_jmp   jmp;
        t_step  target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        chunk: CH_LO, asel: A_SP, gsel: G_WB, acc: ACC_HOLD,
        wb: WB_NONE, jmp: J_NEXT, target: '0
    };

    // saturate a wide signed sum to the 48-bit state range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_IN_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[ACC_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pid_controller_filtered_derivative.sv =====
// ---------------------------------------------------------------------------
// pid_controller_filtered_derivative: tick-gated PID with derivative filter
// Microcoded controller: step counter and control store over one multiplier.
// ---------------------------------------------------------------------------
// Each input transfer is one timer tick carrying setpoint and measured value
// (signed Q16.16). A tick that does not complete the sample period jumps
// straight to the last step and returns the held drive with updated = 0. An
// updating tick runs the 21-step microcode program: seven fixed-point
// products share one 27x25 multiplier, each issued as two 26-bit chunks on
// consecutive steps. The result register holds one finished item, so the
// next tick is taken while a result waits; the program stalls on its last
// step until that register is free. The configuration channel is always
// ready and must only be written while the block is idle.
// ---------------------------------------------------------------------------
module pid_controller_filtered_derivative (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick input: [31:0] setpoint, [63:32] measured
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [2*pidf_pkg::IN_W-1:0]         i_s_tdata,
    // result: [23:0] drive
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pidf_pkg::DRIVE_W-1:0]        o_m_tdata,
    // result flag: [0] updated
    output logic                                o_m_tuser,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pidf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pidf_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_state               r_state, n_state;
    t_step                r_step, n_step;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic                 r_upd, n_upd;
    logic                 r_ovalid, n_ovalid;
    logic [DRIVE_W-1:0]   r_odata, n_odata;
    logic                 r_ouser, n_ouser;
    t_cfg                 r_cfg;

    t_uword               uword;
    t_uword               dp_ctl;
    logic                 s_xfer;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [PERIOD_W-1:0]  period;
    logic                 hold_tick;
    logic [DRIVE_W-1:0]   drive;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_xfer      = i_s_tvalid && o_s_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_GAIN: r_cfg.integral_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_FACTOR:  r_cfg.deriv_factor  <= i_cfg_data[COEF_W-1:0];
                CFG_DERIV_DECAY:   r_cfg.deriv_decay   <= i_cfg_data[COEF_W-1:0];
                CFG_WEIGHT_PROP:   r_cfg.weight_prop   <= i_cfg_data[COEF_W-1:0];
                CFG_WEIGHT_DERIV:  r_cfg.weight_deriv  <= i_cfg_data[COEF_W-1:0];
                CFG_OUTPUT_MAX:    r_cfg.output_max    <= i_cfg_data[DRIVE_W-1:0];
                CFG_SAMPLE_PERIOD: r_cfg.sample_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // tick gate: saturating count, zero period counts as one
    assign cnt_inc   = (r_tick == CNT_MAX) ? r_tick : r_tick + COUNT_WIDTH'(1);
    assign period    = (r_cfg.sample_period == '0) ? PERIOD_W'(1) : r_cfg.sample_period;
    assign hold_tick = (CMP_W'(cnt_inc) < CMP_W'(period)) && (cnt_inc != CNT_MAX);

    // control store
    pidf_ucode_rom u_rom (
        .i_step (r_step),
        .o_word (uword)
    );

    // no write-back outside the program
    always_comb begin
        dp_ctl = uword;
        if (r_state != ST_RUN) begin
            dp_ctl.wb = WB_NONE;
        end
    end

    pidf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (dp_ctl),
        .i_cfg      (r_cfg),
        .i_load     (s_xfer),
        .i_setpoint ($signed(i_s_tdata[IN_W-1:0])),
        .i_measured ($signed(i_s_tdata[2*IN_W-1:IN_W])),
        .o_drive    (drive)
    );

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_tick   = r_tick;
        n_upd    = r_upd;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                    n_upd   = !hold_tick;
                    n_tick  = hold_tick ? cnt_inc : '0;
                end
            end
            ST_RUN: begin
                case (uword.jmp)
                    J_NEXT: n_step = r_step + STEP_W'(1);
                    J_HOLD: n_step = r_upd ? r_step + STEP_W'(1) : uword.target;
                    J_DONE: begin
                        // wait for the result register to be free
                        if (!r_ovalid || i_m_tready) begin
                            n_ovalid = 1'b1;
                            n_odata  = drive;
                            n_ouser  = r_upd;
                            n_state  = ST_IDLE;
                        end
                    end
                    default: n_step = r_step;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_tick   <= '0;
            r_upd    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_tick   <= n_tick;
            r_upd    <= n_upd;
            r_ovalid <= n_ovalid;
            r_odata  <= n_odata;
            r_ouser  <= n_ouser;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // a result appears only from the last program step
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_step) == STEP_FIN))
        else $error("result loaded outside the final step");

    // an updating result comes with a cleared tick count
    a_update_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid) && r_ouser) |-> (r_tick == '0))
        else $error("update without tick count restart");

    // an updated drive is never below one lsb
    a_drive_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ouser) |-> (r_odata != '0))
        else $error("updated drive is zero");

    // the step counter stays inside the program
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_step <= STEP_FIN))
        else $error("step counter ran past the program");

endmodule

// ===== rtl/pidf_ucode_rom.sv =====
// ---------------------------------------------------------------------------
// pidf_ucode_rom: control store of the PID update program
// One control word per step; the first six multiplies overlap.
// ---------------------------------------------------------------------------
module pidf_ucode_rom (
    input  pidf_pkg::t_step  i_step,
    output pidf_pkg::t_uword o_word
);
    import pidf_pkg::*;

    // program listing: a multiply issues its low chunk, then its high chunk;
    // the low product is loaded into the accumulator, the high one added after that,
    // and the scaled result is written back on the following step
    always_comb begin
        o_word = UW_NOP;
        case (i_step)
            // weighted setpoint for the proportional term; skip on a hold tick
            5'd0:  o_word = '{CH_LO, A_SP,    G_WB,     ACC_HOLD, WB_NONE,  J_HOLD, STEP_FIN};
            5'd1:  o_word = '{CH_HI, A_SP,    G_WB,     ACC_LOAD, WB_NONE,  J_NEXT, '0};
            // weighted setpoint for the derivative term
            5'd2:  o_word = '{CH_LO, A_SP,    G_WC,     ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd3:  o_word = '{CH_HI, A_SP,    G_WC,     ACC_LOAD, WB_EP,    J_NEXT, '0};
            // proportional term
            5'd4:  o_word = '{CH_LO, A_EP,    G_K,      ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd5:  o_word = '{CH_HI, A_EP,    G_K,      ACC_LOAD, WB_DIN,   J_NEXT, '0};
            // integral increment
            5'd6:  o_word = '{CH_LO, A_SPM,   G_KI,     ACC_ADD,  WB_DD,    J_NEXT, '0};
            5'd7:  o_word = '{CH_HI, A_SPM,   G_KI,     ACC_LOAD, WB_UP,    J_NEXT, '0};
            // decay of the derivative state
            5'd8:  o_word = '{CH_LO, A_DS,    G_DECAY,  ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd9:  o_word = '{CH_HI, A_DS,    G_DECAY,  ACC_LOAD, WB_INTEG, J_NEXT, '0};
            // gain on the change of the weighted error
            5'd10: o_word = '{CH_LO, A_DD,    G_K,      ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd11: o_word = '{CH_HI, A_DD,    G_K,      ACC_LOAD, WB_TMP,   J_NEXT, '0};
            5'd12: o_word = '{CH_LO, A_INNER, G_FACTOR, ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd13: o_word = '{CH_LO, A_INNER, G_FACTOR, ACC_HOLD, WB_INNER, J_NEXT, '0};
            // filter factor
            5'd14: o_word = '{CH_LO, A_INNER, G_FACTOR, ACC_HOLD, WB_NONE,  J_NEXT, '0};
            5'd15: o_word = '{CH_HI, A_INNER, G_FACTOR, ACC_LOAD, WB_NONE,  J_NEXT, '0};
            5'd16: o_word = '{CH_LO, A_INNER, G_FACTOR, ACC_ADD,  WB_NONE,  J_NEXT, '0};
            5'd17: o_word = '{CH_LO, A_SP,    G_WB,     ACC_HOLD, WB_DS,    J_NEXT, '0};
            // sum and clamp
            5'd18: o_word = '{CH_LO, A_SP,    G_WB,     ACC_HOLD, WB_SUM,   J_NEXT, '0};
            5'd19: o_word = '{CH_LO, A_SP,    G_WB,     ACC_HOLD, WB_CLAMP, J_NEXT, '0};
            // hand the drive to the output register
            5'd20: o_word = '{CH_LO, A_SP,    G_WB,     ACC_HOLD, WB_NONE,  J_DONE, '0};
            default: o_word = UW_NOP;
        endcase
    end

endmodule

// ===== rtl/pidf_datapath.sv =====
// ---------------------------------------------------------------------------
// pidf_datapath: shared multiplier, accumulator and term registers
// Runs one control word per cycle; holds integrator and derivative state.
// ---------------------------------------------------------------------------
module pidf_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pidf_pkg::t_uword                   i_ctl,
    input  pidf_pkg::t_cfg                     i_cfg,
    input  logic                               i_load,
    input  logic signed [pidf_pkg::IN_W-1:0]   i_setpoint,
    input  logic signed [pidf_pkg::IN_W-1:0]   i_measured,
    output logic        [pidf_pkg::DRIVE_W-1:0] o_drive
);
    import pidf_pkg::*;

    // input latches
    logic signed [IN_W-1:0]    r_sp;
    logic signed [IN_W-1:0]    r_ms;
    logic signed [SPM_W-1:0]   r_spm;

    // terms
    logic signed [EP_W-1:0]    r_ep;
    logic signed [DIN_W-1:0]   r_din;
    logic signed [DD_W-1:0]    r_dd;
    logic signed [UP_W-1:0]    r_up;
    logic signed [PRD_W-1:0]   r_inner;
    logic signed [SUM_W-1:0]   r_sum;

    // controller state
    logic signed [ACC_W-1:0]   r_integ;
    logic signed [ACC_W-1:0]   r_ds;
    logic signed [DIN_W-1:0]   r_prev;
    logic        [DRIVE_W-1:0] r_held;

    // multiplier pipeline
    logic signed [PP_W-1:0]    r_pp;
    logic signed [MACC_W-1:0]  r_acc;

    logic signed [A_W-1:0]       a_full;
    logic signed [CHUNK_W:0]     a_chunk;
    logic        [G_W-1:0]       g_sel;
    logic signed [G_W:0]         g_op;
    logic signed [PRD_W-1:0]     prd;
    logic        [DRIVE_W-1:0]   hi_lim;
    logic signed [SUM_W-1:0]     hi_ext;
    logic        [DRIVE_W-1:0]   clamped;

    // operand a select
    always_comb begin
        case (i_ctl.asel)
            A_SP:    a_full = A_W'(r_sp);
            A_EP:    a_full = A_W'(r_ep);
            A_SPM:   a_full = A_W'(r_spm);
            A_DS:    a_full = A_W'(r_ds);
            A_DD:    a_full = A_W'(r_dd);
            A_INNER: a_full = A_W'(r_inner);
            default: a_full = '0;
        endcase
    end

    // low chunk is unsigned, high chunk carries the sign
    always_comb begin
        case (i_ctl.chunk)
            CH_LO:   a_chunk = $signed({1'b0, a_full[CHUNK_W-1:0]});
            CH_HI:   a_chunk = (CHUNK_W + 1)'($signed(a_full[A_W-1:CHUNK_W]));
            default: a_chunk = '0;
        endcase
    end

    // gain select
    always_comb begin
        case (i_ctl.gsel)
            G_WB:     g_sel = G_W'(i_cfg.weight_prop);
            G_WC:     g_sel = G_W'(i_cfg.weight_deriv);
            G_K:      g_sel = i_cfg.prop_gain;
            G_KI:     g_sel = i_cfg.integral_gain;
            G_DECAY:  g_sel = G_W'(i_cfg.deriv_decay);
            G_FACTOR: g_sel = G_W'(i_cfg.deriv_factor);
            default:  g_sel = '0;
        endcase
    end

    assign g_op = $signed({1'b0, g_sel});

    // floor-scaled product taken from the accumulator
    assign prd = r_acc[FRAC_BITS +: PRD_W];

    // drive clamp to one lsb through the upper limit
    assign hi_lim = (i_cfg.output_max == '0) ? DRIVE_W'(1) : i_cfg.output_max;
    assign hi_ext = $signed(SUM_W'(hi_lim));

    always_comb begin
        if (r_sum > hi_ext) begin
            clamped = hi_lim;
        end else if (r_sum < SUM_W'(1)) begin
            clamped = DRIVE_W'(1);
        end else begin
            clamped = r_sum[DRIVE_W-1:0];
        end
    end

    // multiplier and partial-product accumulator
    always_ff @(posedge i_clk) begin
        r_pp <= a_chunk * g_op;
        case (i_ctl.acc)
            ACC_LOAD: r_acc <= MACC_W'(r_pp);
            ACC_ADD:  r_acc <= r_acc + (MACC_W'(r_pp) <<< CHUNK_W);
            default:  r_acc <= r_acc;
        endcase
    end

    // input latch and term write-back
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sp  <= i_setpoint;
            r_ms  <= i_measured;
            r_spm <= SPM_W'(i_setpoint) - SPM_W'(i_measured);
        end
        case (i_ctl.wb)
            WB_EP:    r_ep    <= EP_W'(prd - PRD_W'(r_ms));
            WB_DIN:   r_din   <= DIN_W'(prd - PRD_W'(r_ms));
            WB_DD:    r_dd    <= DD_W'(r_din) - DD_W'(r_prev);
            WB_UP:    r_up    <= UP_W'(prd);
            WB_TMP:   r_inner <= prd;
            WB_INNER: r_inner <= r_inner + prd;
            WB_SUM:   r_sum   <= SUM_W'(r_up) + SUM_W'(r_integ) + SUM_W'(r_ds);
            default:  ;
        endcase
    end

    // controller state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_ds    <= '0;
            r_prev  <= '0;
            r_held  <= '0;
        end else begin
            case (i_ctl.wb)
                WB_DD: r_prev <= r_din;
                WB_INTEG: begin
                    // integrator resets while the setpoint is at or below 1.0
                    if (r_sp > ONE_Q) begin
                        r_integ <= sat_acc(SAT_IN_W'(r_integ) + SAT_IN_W'(prd));
                    end else begin
                        r_integ <= '0;
                    end
                end
                WB_DS:    r_ds   <= sat_acc(SAT_IN_W'(prd));
                WB_CLAMP: r_held <= clamped;
                default:  ;
            endcase
        end
    end

    assign o_drive = r_held;

endmodule
